// ----- hw/rtl/bmft_pkg.sv -----
// Package for the block-mapping flash translation core.
// Holds sizes, result command codes and the page address width.
`default_nettype none
package bmft_pkg;
   localparam int PagesPerBlockDef = 32;
   localparam int NumBlocksDef     = 256;
   localparam int AddrW            = 13;
   localparam int CmdW             = 3;

   localparam logic [CmdW-1:0] CMD_READ    = 3'd0;
   localparam logic [CmdW-1:0] CMD_PROGRAM = 3'd1;
   localparam logic [CmdW-1:0] CMD_COPY    = 3'd2;
   localparam logic [CmdW-1:0] CMD_ERASE   = 3'd3;
   localparam logic [CmdW-1:0] CMD_EMPTY   = 3'd4;
   localparam logic [CmdW-1:0] CMD_NOFREE  = 3'd5;
   localparam logic [CmdW-1:0] CMD_RANGE   = 3'd6;
endpackage
`default_nettype wire

// ----- hw/rtl/bmft_if.sv -----
// Valid/ready channel interfaces for request and response transfers.
// Depends on bmft_pkg for field widths.
`default_nettype none
interface bmft_req_if import bmft_pkg::*; ();
   logic             valid;
   logic             ready;
   logic             req_type;
   logic [AddrW-1:0] key;
   modport source (output valid, req_type, key, input ready);
   modport sink   (input valid, req_type, key, output ready);
endinterface

interface bmft_rsp_if import bmft_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [CmdW-1:0]  cmd;
   logic [AddrW-1:0] page_addr;
   logic [AddrW-1:0] src_addr;
   logic             last;
   modport source (output valid, cmd, page_addr, src_addr, last, input ready);
   modport sink   (input valid, cmd, page_addr, src_addr, last, output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/block_mapping_flash_translation_core.sv -----
// Block-mapping flash translation core: top level with sequencer and state stores.
// Depends on bmft_pkg and the channel interfaces in bmft_if.sv.
//
// A request transfer on req_ carries a read/write flag and a logical page key.
// Responses leave on rsp_ one transfer at a time; last marks the final one.
// After reset a clearing pass marks every logical block unmapped and every physical
// page free; no request is taken meanwhile.
// A key out of range is answered in the cycle after its request transfer.
// Otherwise states S_DIV, S_MAP, S_PAGE and S_DEC split the key and look up the
// maps, and a read or an in-place program is answered from S_DEC.
// A write to an unmapped block, or an overwrite, then walks the block-in-use flags
// from the search pointer through S_SRCH and S_MOVE per block. An overwrite that
// finds a free block emits PAGES_PER_BLOCK+1 responses, one per cycle while the
// receiver is ready; all but the last update a page flag in each of the two blocks.
// The response register holds its data while the receiver stalls, and the
// sequencer waits; one request is in work at a time, and the next request
// transfer can come in the cycle after the last response transfer.
`default_nettype none
module block_mapping_flash_translation_core
   import bmft_pkg::*;
#(
   parameter int PAGES_PER_BLOCK = PagesPerBlockDef,
   parameter int NUM_BLOCKS      = NumBlocksDef
) (
   input wire logic  clock,
   input wire logic  reset,
   bmft_req_if.sink  req,
   bmft_rsp_if.source rsp
);
   localparam int BW   = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
   localparam int OW   = $clog2(PAGES_PER_BLOCK);
   localparam int TP   = NUM_BLOCKS * PAGES_PER_BLOCK;
   localparam int PW   = $clog2(TP);
   localparam int KW   = AddrW + 1;
   localparam int DIV_SH  = AddrW + OW;
   localparam int DIV_MUL = ((1 << DIV_SH) + PAGES_PER_BLOCK - 1) / PAGES_PER_BLOCK;

   localparam logic [3:0] S_CLR   = 4'd0;
   localparam logic [3:0] S_IDLE  = 4'd1;
   localparam logic [3:0] S_DIV   = 4'd2;
   localparam logic [3:0] S_MAP   = 4'd3;
   localparam logic [3:0] S_PAGE  = 4'd4;
   localparam logic [3:0] S_DEC   = 4'd5;
   localparam logic [3:0] S_SRCH  = 4'd6;
   localparam logic [3:0] S_MOVE  = 4'd7;
   localparam logic [3:0] S_OUT   = 4'd8;
   localparam logic [3:0] S_ERASE = 4'd9;

   logic [BW:0] map_mem [NUM_BLOCKS];
   logic        use_mem [NUM_BLOCKS];
   logic        pfree_mem [TP];

   logic [3:0]      st_ff, st_in;
   logic [BW:0]     cnt_ff, cnt_in;
   logic            wr_ff, wr_in;
   logic [KW-1:0]   rem_ff, rem_in;
   logic [BW-1:0]   lba_ff, lba_in;
   logic [BW-1:0]   ptr_ff, ptr_in;
   logic            wrap_ff, wrap_in;
   logic [BW:0]     maprd_ff;
   logic            userd_ff, pfrd_ff;
   logic [BW-1:0]   pba_ff, pba_in, nba_ff, nba_in;
   logic [OW:0]     off_ff, off_in, i_ff, i_in;
   logic            mapped_ff, mapped_in;
   logic            ov_ff, ov_in;
   logic            ovld_ff, ovld_in;
   logic [CmdW-1:0] ocmd_ff, ocmd_in;
   logic [AddrW-1:0] opage_ff, opage_in, osrc_ff, osrc_in;
   logic            olast_ff, olast_in;

   logic            map_we, use_we, use_we2, pf_we, pf_we2, pf_d, pf_d2;
   logic [BW-1:0]   map_wa, use_wa, use_wa2;
   logic [BW:0]     map_wd;
   logic            use_wd, use_wd2;
   logic [PW-1:0]   pf_wa, pf_wa2, pf_ra;
   logic [BW-1:0]   map_ra, use_ra;
   logic            can_emit;
   logic [31:0]     quo, offs;

   assign req.ready     = (st_ff == S_IDLE) && !ovld_ff;
   assign rsp.valid     = ovld_ff;
   assign rsp.cmd       = ocmd_ff;
   assign rsp.page_addr = opage_ff;
   assign rsp.src_addr  = osrc_ff;
   assign rsp.last      = olast_ff;
   assign can_emit      = !ovld_ff || rsp.ready;

   // The reciprocal product gives the exact block number for every 13-bit key.
   assign quo  = (32'(rem_ff) * 32'(DIV_MUL)) >> DIV_SH;
   assign offs = 32'(rem_ff) - 32'(lba_ff) * 32'(PAGES_PER_BLOCK);

   function automatic logic [AddrW-1:0] paddr(logic [BW-1:0] b, logic [OW:0] o);
      logic [31:0] t;
      t = 32'(b) * 32'(PAGES_PER_BLOCK) + 32'(o);
      return t[AddrW-1:0];
   endfunction

   function automatic logic [PW-1:0] pidx(logic [BW-1:0] b, logic [OW:0] o);
      logic [31:0] t;
      t = 32'(b) * 32'(PAGES_PER_BLOCK) + 32'(o);
      return t[PW-1:0];
   endfunction

   always_ff @(posedge clock) begin
      maprd_ff <= map_mem[map_ra];
      userd_ff <= use_mem[use_ra];
      pfrd_ff  <= pfree_mem[pf_ra];
      if (map_we) map_mem[map_wa] <= map_wd;
      if (use_we) use_mem[use_wa] <= use_wd;
      if (use_we2) use_mem[use_wa2] <= use_wd2;
      if (pf_we) pfree_mem[pf_wa] <= pf_d;
      if (pf_we2) pfree_mem[pf_wa2] <= pf_d2;
   end

   always_comb begin
      st_in = st_ff; cnt_in = cnt_ff; wr_in = wr_ff; rem_in = rem_ff;
      lba_in = lba_ff; ptr_in = ptr_ff; wrap_in = wrap_ff; pba_in = pba_ff;
      nba_in = nba_ff; off_in = off_ff; i_in = i_ff; mapped_in = mapped_ff;
      ov_in = ov_ff;
      ovld_in = ovld_ff && !rsp.ready;
      ocmd_in = ocmd_ff; opage_in = opage_ff; osrc_in = osrc_ff; olast_in = olast_ff;
      map_we = 1'b0; map_wa = lba_ff; map_wd = '0;
      use_we = 1'b0; use_wa = nba_ff; use_wd = 1'b1;
      use_we2 = 1'b0; use_wa2 = pba_ff; use_wd2 = 1'b0;
      pf_we = 1'b0; pf_wa = '0; pf_d = 1'b0;
      pf_we2 = 1'b0; pf_wa2 = '0; pf_d2 = 1'b1;
      map_ra = lba_ff; use_ra = ptr_ff; pf_ra = pidx(pba_ff, off_ff);
      unique case (st_ff)
         S_CLR: begin
            pf_we = 1'b1; pf_wa = pidx(cnt_ff[BW-1:0], i_ff); pf_d = 1'b1;
            map_we = (i_ff == '0); map_wa = cnt_ff[BW-1:0];
            use_we = (i_ff == '0); use_wa = cnt_ff[BW-1:0]; use_wd = 1'b0;
            if (i_ff == (OW+1)'(PAGES_PER_BLOCK - 1)) begin
               i_in = '0;
               cnt_in = cnt_ff + 1'b1;
               if (cnt_ff == (BW+1)'(NUM_BLOCKS - 1)) st_in = S_IDLE;
            end else begin
               i_in = i_ff + 1'b1;
            end
         end
         S_IDLE: begin
            if (req.valid && req.ready) begin
               wr_in = req.req_type;
               rem_in = KW'(req.key);
               cnt_in = '0;
               if (32'(req.key) >= 32'(TP)) begin
                  ovld_in = 1'b1; ocmd_in = CMD_RANGE; opage_in = '0;
                  osrc_in = '0; olast_in = 1'b1;
               end else begin
                  st_in = S_DIV;
               end
            end
         end
         S_DIV: begin
            lba_in = quo[BW-1:0];
            st_in = S_MAP;
         end
         S_MAP: begin
            off_in = offs[OW:0];
            st_in = S_PAGE;
         end
         S_PAGE: begin
            mapped_in = maprd_ff[BW];
            pba_in = maprd_ff[BW-1:0];
            pf_ra = pidx(maprd_ff[BW-1:0], off_ff);
            st_in = S_DEC;
         end
         S_DEC: begin
            pf_ra = pidx(pba_ff, off_ff);
            if (can_emit) begin
               if (!wr_ff) begin
                  ovld_in = 1'b1; osrc_in = '0; olast_in = 1'b1;
                  if (!mapped_ff) begin
                     ocmd_in = CMD_EMPTY; opage_in = '0;
                  end else begin
                     ocmd_in = CMD_READ; opage_in = paddr(pba_ff, off_ff);
                  end
                  st_in = S_IDLE;
               end else if (!mapped_ff) begin
                  ov_in = 1'b0; wrap_in = 1'b0; st_in = S_SRCH;
               end else if (pfrd_ff) begin
                  pf_we = 1'b1; pf_wa = pidx(pba_ff, off_ff); pf_d = 1'b0;
                  use_we2 = 1'b1; use_wd2 = 1'b1;
                  ovld_in = 1'b1; ocmd_in = CMD_PROGRAM;
                  opage_in = paddr(pba_ff, off_ff); osrc_in = '0; olast_in = 1'b1;
                  st_in = S_IDLE;
               end else begin
                  ov_in = 1'b1; wrap_in = 1'b0; st_in = S_SRCH;
               end
            end
         end
         S_SRCH: begin
            // Reads one in-use flag, and S_MOVE checks it before the next is read; the read data is registered.
            use_ra = ptr_ff;
            st_in = S_MOVE;
         end
         S_MOVE: begin
            if (!userd_ff) begin
               nba_in = ptr_ff;
               map_we = 1'b1; map_wd = {1'b1, ptr_ff};
               use_we = 1'b1; use_wa = ptr_ff; use_wd = 1'b1;
               if (ov_ff) begin
                  use_we2 = 1'b1; use_wd2 = 1'b0;
                  i_in = '0; st_in = S_OUT;
               end else begin
                  pf_we = 1'b1; pf_wa = pidx(ptr_ff, off_ff); pf_d = 1'b0;
                  st_in = S_ERASE;
               end
            end else if (32'(ptr_ff) == NUM_BLOCKS - 1) begin
               ptr_in = '0;
               if (wrap_ff) begin
                  st_in = S_ERASE; nba_in = '0;
                  ov_in = 1'b0; mapped_in = 1'b0;
               end else begin
                  wrap_in = 1'b1; st_in = S_SRCH;
               end
            end else begin
               ptr_in = ptr_ff + 1'b1;
               st_in = S_SRCH;
            end
            if (!userd_ff) mapped_in = 1'b1;
         end
         S_OUT: begin
            if (can_emit) begin
               pf_we = 1'b1; pf_wa = pidx(nba_ff, i_ff); pf_d = 1'b0;
               pf_we2 = 1'b1; pf_wa2 = pidx(pba_ff, i_ff); pf_d2 = 1'b1;
               ovld_in = 1'b1; olast_in = 1'b0;
               opage_in = paddr(nba_ff, i_ff);
               if (i_ff == off_ff) begin
                  ocmd_in = CMD_PROGRAM; osrc_in = '0;
               end else begin
                  ocmd_in = CMD_COPY; osrc_in = paddr(pba_ff, i_ff);
               end
               i_in = i_ff + 1'b1;
               if (i_ff == (OW+1)'(PAGES_PER_BLOCK - 1)) begin
                  st_in = S_ERASE;
               end
            end
         end
         S_ERASE: begin
            if (can_emit) begin
               ovld_in = 1'b1; olast_in = 1'b1; osrc_in = '0;
               if (ov_ff) begin
                  ocmd_in = CMD_ERASE; opage_in = paddr(pba_ff, '0);
               end else if (mapped_ff) begin
                  ocmd_in = CMD_PROGRAM; opage_in = paddr(nba_ff, off_ff);
               end else begin
                  ocmd_in = CMD_NOFREE; opage_in = '0;
               end
               i_in = '0;
               st_in = S_IDLE;
            end
         end
         default: st_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= S_CLR; cnt_ff <= '0; i_ff <= '0; ptr_ff <= '0;
         ovld_ff <= 1'b0; wrap_ff <= 1'b0; ov_ff <= 1'b0;
      end else begin
         st_ff <= st_in; cnt_ff <= cnt_in; i_ff <= i_in; ptr_ff <= ptr_in;
         ovld_ff <= ovld_in; wrap_ff <= wrap_in; ov_ff <= ov_in;
      end
      wr_ff <= wr_in; rem_ff <= rem_in; lba_ff <= lba_in; pba_ff <= pba_in;
      nba_ff <= nba_in; off_ff <= off_in; mapped_ff <= mapped_in;
      ocmd_ff <= ocmd_in; opage_ff <= opage_in; osrc_ff <= osrc_in;
      olast_ff <= olast_in;
   end
endmodule
`default_nettype wire
